@@ rtl/rdsc_pkg.sv @@
// Package for the radix digit string converter: shared types, constants,
// radix clamping and the digit-to-ASCII mapping. No dependencies.
package rdsc_pkg;

   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;

   typedef logic [RADIX_BITS-1:0] radix_type;
   typedef logic [CHAR_BITS-1:0]  char_type;

   localparam radix_type RADIX_MIN      = 6'd2;
   localparam radix_type RADIX_MAX      = 6'd36;
   localparam radix_type RADIX_RESET    = 6'd10;
   localparam radix_type DECIMAL_DIGITS = 6'd10;
   localparam char_type  ASCII_ZERO     = 7'd48;
   localparam char_type  LETTER_BASE    = 7'd55;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_SHOW  = 4'b1000
   } state_type;

   function automatic radix_type clamp_radix(input radix_type r);
      radix_type res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic char_type digit_to_ascii(input radix_type d);
      char_type res;
      if (d < DECIMAL_DIGITS) begin
         res = ASCII_ZERO + char_type'(d);
      end else begin
         res = LETTER_BASE + char_type'(d);
      end
      return res;
   endfunction

endpackage

@@ rtl/rdsc_if.sv @@
// Valid/ready channel interfaces of the radix digit string converter.
// Depends on rdsc_pkg.
interface rdsc_req_if #(parameter int VALUE_BITS = 31);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rdsc_rsp_if;
   logic               valid;
   logic               ready;
   rdsc_pkg::char_type digit_char;
   logic               last;
   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

interface rdsc_csr_if;
   logic                valid;
   logic                ready;
   rdsc_pkg::radix_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rdsc_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rdsc_pkg.
module rdsc_divider #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  rdsc_pkg::radix_type   divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output rdsc_pkg::radix_type   remainder
);
   import rdsc_pkg::*;

   localparam int CNTW = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   radix_type             rem_ff, rem_in;
   logic [RADIX_BITS:0]   trial;
   logic [RADIX_BITS:0]   diff;

   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(VALUE_BITS - 1);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[RADIX_BITS-1:0];
            quo_in = {quo_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[RADIX_BITS-1:0];
            quo_in = {quo_ff[VALUE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/radix_digit_string_converter_unit.sv @@
// Radix digit string converter: integer to ASCII digits in radix 2..36.
// Depends on rdsc_pkg, rdsc_if and rdsc_divider.
//
// Usage:
//   csr: one write beat sets the radix (6 bits); 0 and 1 act as 2, values
//        above 36 act as 36. Reset value is 10. Write only while idle.
//   req: one beat carries the value; req.ready is high only while idle.
//   rsp: one beat per digit, most significant first, '0'-'9' then 'A'-'Z';
//        last marks the least significant digit. Zero gives a single '0'.
// Timing:
//   Each digit is computed in turn by the shared serial divider, then each
//   digit is read from the digit store and presented, waiting on the receiver.
//   The next req beat is taken the cycle after the last rsp beat.
// Reset clears the sequencer and sets the radix to 10; the digit store is
// not cleared. A stalled rsp holds its digit until taken.
module radix_digit_string_converter_unit #(
   parameter int VALUE_BITS = 31
) (
   input logic       clock,
   input logic       reset,
   rdsc_req_if.sink  req,
   rdsc_rsp_if.source rsp,
   rdsc_csr_if.sink  csr
);
   import rdsc_pkg::*;

   localparam int IDXW = $clog2(VALUE_BITS);

   state_type             state_ff, state_in;
   logic [IDXW-1:0]       idx_ff, idx_in;
   radix_type             radix_ff;
   radix_type             rd_data_ff;
   radix_type             store_mem [VALUE_BITS];

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   radix_type             div_remainder;
   logic                  store_we;

   rdsc_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (clamp_radix(radix_ff)),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign store_we  = (state_ff == ST_DIV) && div_done;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      case (state_ff)
         ST_IDLE: begin
            div_dividend = req.value;
            if (req.valid) begin
               div_start = 1'b1;
               idx_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_quotient == '0) begin
                  state_in = ST_FETCH;
               end else begin
                  div_start = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp.ready) begin
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         radix_ff <= RADIX_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr.valid) begin
            radix_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[idx_ff] <= div_remainder;
      end
      if (state_ff == ST_FETCH) begin
         rd_data_ff <= store_mem[idx_ff];
      end
   end

   assign rsp.valid      = (state_ff == ST_SHOW);
   assign rsp.digit_char = digit_to_ascii(rd_data_ff);
   assign rsp.last       = (idx_ff == '0);

endmodule

@@ rtl/rdsc_checker.sv @@
// Port-level checks for radix_digit_string_converter_unit, attached by bind.
// Depends on rdsc_pkg.
module rdsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rdsc_pkg::char_type rsp_digit_char,
   input logic               rsp_last
);

   hold_stalled_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))
      else $error("stalled rsp beat changed");

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while a conversion runs");

   no_req_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req ready while digits are emitted");

   legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) ||
                    (rsp_digit_char >= 7'd65 && rsp_digit_char <= 7'd90))
      else $error("digit character out of range");

   drop_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("rsp beat after last digit");

endmodule

bind radix_digit_string_converter_unit rdsc_checker u_rdsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_digit_char (rsp.digit_char),
   .rsp_last       (rsp.last)
);

@@ verif/digit_string_checker.sv @@
`timescale 1ns / 100ps
// Checker for the radix digit string converter: tracks the radix, predicts the
// digit beats of each accepted value and compares them with the rsp channel.
// Depends on rdsc_pkg and the rdsc_if interfaces.
module digit_string_checker #(
   parameter int VALUE_BITS = 31
) (
   input  logic clock,
   input  logic reset,
   rdsc_req_if  req,
   rdsc_rsp_if  rsp,
   rdsc_csr_if  csr,
   output int   error_count,
   output int   pending_digits,
   output int   digits_checked
);
   import rdsc_pkg::*;

   localparam radix_type DIGIT_SPLIT   = 6'd10;
   localparam char_type  CHAR_ZERO     = 7'h30;
   localparam char_type  CHAR_LETTER_0 = 7'h37;

   typedef struct packed {
      char_type digit_char;
      logic     last;
   } digit_beat_type;

   digit_beat_type digit_queue[$];
   digit_beat_type wanted;
   radix_type      radix_setting = RADIX_RESET;
   int             errors  = 0;
   int             checked = 0;

   function automatic char_type ascii_of(input radix_type d);
      if (d < DIGIT_SPLIT) begin
         return CHAR_ZERO + char_type'(d);
      end
      return CHAR_LETTER_0 + char_type'(d);
   endfunction

   function automatic void push_digit_string(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] rest;
      radix_type             base;
      radix_type             remainders[VALUE_BITS];
      int                    count;
      int                    k;
      digit_beat_type        beat;
      base = radix_setting;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      rest  = value;
      count = 0;
      if (rest == '0) begin
         remainders[0] = '0;
         count = 1;
      end else begin
         while (rest != '0 && count < VALUE_BITS) begin
            remainders[count] = radix_type'(rest % base);
            rest = rest / base;
            count++;
         end
      end
      for (k = count - 1; k >= 0; k--) begin
         beat.digit_char = ascii_of(remainders[k]);
         beat.last       = (k == 0);
         digit_queue     = {digit_queue, beat};
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         radix_setting = RADIX_RESET;
         digit_queue.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (digit_queue.size() == 0) begin
               $error("unexpected digit beat: digit_char %0d, last %0b",
                      rsp.digit_char, rsp.last);
               errors++;
            end else begin
               wanted = digit_queue.pop_front();
               if (rsp.digit_char !== wanted.digit_char) begin
                  $error("digit_char mismatch: expected %0d, actual %0d",
                         wanted.digit_char, rsp.digit_char);
                  errors++;
               end
               if (rsp.last !== wanted.last) begin
                  $error("last mismatch: expected %0b, actual %0b", wanted.last, rsp.last);
                  errors++;
               end
               checked++;
            end
         end
         if (csr.valid && csr.ready) begin
            radix_setting = csr.data;
         end
         if (req.valid && req.ready) begin
            push_digit_string(req.value);
         end
      end
      pending_digits <= digit_queue.size();
      error_count    <= errors;
      digits_checked <= checked;
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Top of the radix digit string converter testbench: clock, reset, stimulus
// and verdict. Depends on rdsc_pkg, rdsc_if, the converter and digit_string_checker.
module testbench;
   import rdsc_pkg::*;

   localparam int VALUE_BITS   = 31;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 1200;
   localparam int HOLD_AFTER   = 150;
   localparam int PHASE_ITEMS  = 33;
   localparam int SETTLE_TIME  = 64;

   typedef logic [VALUE_BITS-1:0] value_type;
   localparam value_type VALUE_MAX = '1;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_MOSTLY
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset;

   rdsc_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus();
   rdsc_rsp_if rsp_bus();
   rdsc_csr_if csr_bus();

   int error_count;
   int pending_digits;
   int digits_checked;

   int values_sent    = 0;
   int radix_writes   = 0;
   int digits_taken   = 0;
   int stall_cycles   = 0;
   int mode_left      = 0;
   bit long_hold_done = 1'b0;
   ready_mode_type ready_mode = READY_ALWAYS;

   radix_digit_string_converter_unit #(.VALUE_BITS(VALUE_BITS)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   digit_string_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .csr            (csr_bus),
      .error_count    (error_count),
      .pending_digits (pending_digits),
      .digits_checked (digits_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random ready pattern, plus one long hold-off while values are offered
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            digits_taken++;
         end
         if (!reset && !long_hold_done && digits_taken >= HOLD_AFTER && req_bus.valid) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            case (ready_mode)
               READY_ALWAYS: begin
                  rsp_bus.ready <= 1'b1;
               end
               READY_HALF: begin
                  rsp_bus.ready <= 1'($urandom_range(0, 1));
               end
               READY_SPARSE: begin
                  rsp_bus.ready <= ($urandom_range(0, 9) == 0);
               end
               default: begin
                  rsp_bus.ready <= (mode_left % 4 != 0);
               end
            endcase
         end
      end
   end

   function automatic value_type random_value();
      int        width;
      value_type v;
      width = $urandom_range(0, VALUE_BITS);
      if ($urandom_range(0, 2) == 0) begin
         width = VALUE_BITS;
      end
      v = value_type'($urandom);
      if (width < VALUE_BITS) begin
         v = v & ((value_type'(1) << width) - value_type'(1));
      end
      return v;
   endfunction

   task automatic send_value(input value_type v);
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      values_sent++;
   endtask

   task automatic wait_for_digits();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_digits != 0) @(posedge clock);
   endtask

   task automatic write_radix(input radix_type r);
      wait_for_digits();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= r;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      radix_writes++;
   endtask

   task automatic run_random_phase(input radix_type r, input int count);
      int remaining;
      int burst;
      int gap;
      write_radix(r);
      remaining = count;
      while (remaining > 0) begin
         burst = $urandom_range(1, 12);
         if (burst > remaining) begin
            burst = remaining;
         end
         repeat (burst) send_value(random_value());
         remaining -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      radix_type r;
      int        phase;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= RADIX_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_value('0);
      send_value(value_type'(1));
      send_value(value_type'(9));
      send_value(value_type'(10));
      send_value(VALUE_MAX);
      write_radix(6'd2);
      send_value('0);
      send_value(value_type'(1));
      send_value(VALUE_MAX);
      send_value(value_type'(1) << (VALUE_BITS - 1));
      write_radix(6'd36);
      send_value(value_type'(35));
      send_value(value_type'(36));
      send_value('0);
      send_value(VALUE_MAX);
      write_radix(6'd16);
      send_value(31'h5555_5555);
      send_value(31'h2AAA_AAAA);
      write_radix(6'd0);
      send_value(value_type'(5));
      write_radix(6'd1);
      send_value(value_type'(6));
      write_radix(6'd37);
      send_value(value_type'(1296));
      write_radix(6'd63);
      send_value(value_type'(1295));

      for (phase = 0; phase < 12; phase++) begin
         if (phase == 0) begin
            r = RADIX_MIN;
         end else if (phase == 1) begin
            r = RADIX_MAX;
         end else if ($urandom_range(0, 4) == 0) begin
            r = radix_type'($urandom_range(0, 63));
         end else begin
            r = radix_type'($urandom_range(2, 36));
         end
         run_random_phase(r, PHASE_ITEMS);
      end

      wait_for_digits();
      repeat (SETTLE_TIME) @(posedge clock);
      $display("Converted %0d values under %0d radix writes; %0d digit beats checked.",
               values_sent, radix_writes, digits_checked);
      $display("Receiver long hold-off applied: %0b.", long_hold_done);
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
